FILE: rtl/core/i2cs_pkg.sv
`timescale 1ns / 1ps

package i2cs_pkg;

   // event codes on the request word
   localparam logic [1:0] OP_START    = 2'd0;
   localparam logic [1:0] OP_OVERFLOW = 2'd1;
   localparam logic [1:0] OP_LOAD     = 2'd2;
   localparam logic [1:0] OP_NONE     = 2'd3;

   // shifter actions on the response word
   localparam logic [2:0] ACT_NONE      = 3'd0;
   localparam logic [2:0] ACT_RELEASE   = 3'd1;
   localparam logic [2:0] ACT_RECEIVE   = 3'd2;
   localparam logic [2:0] ACT_SEND_ACK  = 3'd3;
   localparam logic [2:0] ACT_SEND_BYTE = 3'd4;
   localparam logic [2:0] ACT_READ_ACK  = 3'd5;

   localparam logic [7:0] GENERAL_CALL = 8'h00;
   localparam logic [7:0] BYTE_NULL    = 8'h00;

   // wide enough for any position or index compare over the parameter ranges
   localparam int CMP_W = 9;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ADDRESS,
      PH_SEND,
      PH_ASK_ACK,
      PH_CHECK_ACK,
      PH_ASK_DATA,
      PH_TAKE_DATA
   } phase_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] shift_data;
      logic [4:0] tx_index;
      logic [7:0] tx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] shift_out;
      logic       busy_res;
      logic       rx_valid;
      logic [1:0] rx_index;
      logic [7:0] rx_byte;
   } rsp_type;

endpackage

FILE: rtl/core/i2cs_ram.sv
`timescale 1ns / 1ps

module i2cs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/i2cs_txbuf.sv
`timescale 1ns / 1ps

// Transmit store. Read address is the next transmit position, so the byte
// at the current position is ready when the next event is processed.
module i2cs_txbuf #(
   parameter int TX_DEPTH = 32,
   localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1,
   localparam int PW = $clog2(TX_DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_req,
   input  logic [4:0]    wr_index,
   input  logic [7:0]    wr_byte,
   input  logic [PW-1:0] rd_pos,
   output logic [7:0]    head
);

   logic [i2cs_pkg::CMP_W-1:0] wr_wide;
   logic [i2cs_pkg::CMP_W-1:0] rd_wide;
   logic                       wr_en;
   logic                       rd_ok;
   logic [AW-1:0]              wr_addr;
   logic [AW-1:0]              rd_addr;
   logic [7:0]                 ram_q;
   logic                       hit_ff;
   logic                       hit_in;
   logic [7:0]                 byp_ff;

   assign wr_wide = i2cs_pkg::CMP_W'(wr_index);
   assign rd_wide = i2cs_pkg::CMP_W'(rd_pos);
   // drop loads beyond the store
   assign wr_en   = wr_req && (wr_wide < i2cs_pkg::CMP_W'(TX_DEPTH));
   assign rd_ok   = rd_wide < i2cs_pkg::CMP_W'(TX_DEPTH);
   assign wr_addr = wr_wide[AW-1:0];
   assign rd_addr = rd_ok ? rd_wide[AW-1:0] : '0;
   assign hit_in  = wr_en && rd_ok && (wr_addr == rd_addr);

   i2cs_ram #(
      .WIDTH (8),
      .DEPTH (TX_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_byte),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // forward a load that lands on the entry being prefetched
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
      byp_ff <= wr_byte;
   end

   assign head = hit_ff ? byp_ff : ram_q;

endmodule

FILE: rtl/core/i2cs_step.sv
`timescale 1ns / 1ps

// One event against the current protocol state: next state and result word.
module i2cs_step #(
   parameter int TX_DEPTH = 32,
   parameter int RX_COUNT = 4,
   localparam int PW = $clog2(TX_DEPTH + 1),
   localparam int RW = (RX_COUNT > 0) ? $clog2(RX_COUNT + 1) : 1
) (
   input  i2cs_pkg::req_type   req,
   input  i2cs_pkg::phase_type phase,
   input  logic                busy,
   input  logic [PW-1:0]       tx_pos,
   input  logic [RW-1:0]       rx_pos,
   input  logic [7:0]          head,
   input  logic [6:0]          own_address,
   output i2cs_pkg::phase_type phase_in,
   output logic                busy_in,
   output logic [PW-1:0]       tx_pos_in,
   output logic [RW-1:0]       rx_pos_in,
   output i2cs_pkg::rsp_type   rsp
);

   logic       addr_hit;
   logic       nack;
   logic       tx_more;
   logic       rx_last;
   logic [6:0] rx_wide;

   assign addr_hit = (req.shift_data == i2cs_pkg::GENERAL_CALL)
                     || (req.shift_data[7:1] == own_address);
   assign nack     = req.shift_data != 8'd0;
   assign tx_more  = (i2cs_pkg::CMP_W'(tx_pos) < i2cs_pkg::CMP_W'(TX_DEPTH))
                     && (head != i2cs_pkg::BYTE_NULL);
   assign rx_wide  = 7'(rx_pos);
   assign rx_last  = (rx_wide + 7'd1) >= 7'(RX_COUNT);

   // next state
   always_comb begin
      phase_in  = phase;
      busy_in   = busy;
      tx_pos_in = tx_pos;
      rx_pos_in = rx_pos;
      case (req.operation)
         i2cs_pkg::OP_START: begin
            phase_in = i2cs_pkg::PH_ADDRESS;
         end
         i2cs_pkg::OP_OVERFLOW: begin
            case (phase)
               i2cs_pkg::PH_ADDRESS: begin
                  if (addr_hit) begin
                     busy_in   = 1'b1;
                     rx_pos_in = '0;
                     if (req.shift_data[0]) begin
                        phase_in  = i2cs_pkg::PH_SEND;
                        tx_pos_in = '0;
                     end else begin
                        phase_in = i2cs_pkg::PH_ASK_DATA;
                     end
                  end else begin
                     phase_in = i2cs_pkg::PH_IDLE;
                     busy_in  = 1'b0;
                  end
               end
               i2cs_pkg::PH_SEND, i2cs_pkg::PH_CHECK_ACK: begin
                  if ((phase == i2cs_pkg::PH_CHECK_ACK && nack) || !tx_more) begin
                     phase_in = i2cs_pkg::PH_IDLE;
                     busy_in  = 1'b0;
                  end else begin
                     phase_in  = i2cs_pkg::PH_ASK_ACK;
                     tx_pos_in = tx_pos + PW'(1);
                  end
               end
               i2cs_pkg::PH_ASK_ACK: begin
                  phase_in = i2cs_pkg::PH_CHECK_ACK;
               end
               i2cs_pkg::PH_ASK_DATA: begin
                  phase_in = i2cs_pkg::PH_TAKE_DATA;
               end
               i2cs_pkg::PH_TAKE_DATA: begin
                  rx_pos_in = rx_pos + RW'(1);
                  if (rx_last) begin
                     phase_in = i2cs_pkg::PH_IDLE;
                     busy_in  = 1'b0;
                  end else begin
                     phase_in = i2cs_pkg::PH_ASK_DATA;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // result word
   always_comb begin
      rsp          = '0;
      rsp.busy_res = busy_in;
      case (req.operation)
         i2cs_pkg::OP_START: begin
            rsp.action = i2cs_pkg::ACT_RECEIVE;
         end
         i2cs_pkg::OP_OVERFLOW: begin
            case (phase)
               i2cs_pkg::PH_ADDRESS: begin
                  rsp.action = addr_hit ? i2cs_pkg::ACT_SEND_ACK : i2cs_pkg::ACT_RELEASE;
               end
               i2cs_pkg::PH_SEND, i2cs_pkg::PH_CHECK_ACK: begin
                  if ((phase == i2cs_pkg::PH_CHECK_ACK && nack) || !tx_more) begin
                     rsp.action = i2cs_pkg::ACT_RELEASE;
                  end else begin
                     rsp.action    = i2cs_pkg::ACT_SEND_BYTE;
                     rsp.shift_out = head;
                  end
               end
               i2cs_pkg::PH_ASK_ACK: begin
                  rsp.action = i2cs_pkg::ACT_READ_ACK;
               end
               i2cs_pkg::PH_ASK_DATA: begin
                  rsp.action = i2cs_pkg::ACT_RECEIVE;
               end
               i2cs_pkg::PH_TAKE_DATA: begin
                  rsp.action   = rx_last ? i2cs_pkg::ACT_RELEASE : i2cs_pkg::ACT_SEND_ACK;
                  rsp.rx_valid = 1'b1;
                  rsp.rx_index = rx_wide[1:0];
                  rsp.rx_byte  = req.shift_data;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: rtl/core/i2c_slave_byte_sequencer.sv
`timescale 1ns / 1ps

// Byte-level sequencer of an I2C slave. Each request word is one event (start
// condition, shifter overflow with the sampled byte or ack bit, or a host load
// of a transmit store entry) and yields exactly one response word with the
// shifter action, the byte to load, the busy flag and any received byte.
// Throughput is one event per clock while rsp_stall is low: the protocol
// step is a single combinational pass between the request register and the
// response register, and the transmit store byte at the current read
// position is prefetched from the store RAM, addressed by the next position,
// so the store's single read port never stalls the flow. A request waits in
// the request register until it fires; its response is then registered. The
// request register doubles as a skid stage, so a new word is taken while a
// finished response waits on rsp_stall. The slave address is written through
// the csr port, which is always ready; write it only while no event is in
// flight. Transmit store entries read before being loaded return unknown data.
module i2c_slave_byte_sequencer #(
   parameter int TX_DEPTH = 32,
   parameter int RX_COUNT = 4,
   localparam int PW = $clog2(TX_DEPTH + 1),
   localparam int RW = (RX_COUNT > 0) ? $clog2(RX_COUNT + 1) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  i2cs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output i2cs_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [6:0]        csr_data
);

   // request stage
   logic              in_valid_ff;
   logic              in_valid_in;
   i2cs_pkg::req_type in_data_ff;

   // response stage
   logic              out_valid_ff;
   logic              out_valid_in;
   i2cs_pkg::rsp_type out_data_ff;

   // protocol state
   i2cs_pkg::phase_type phase_ff;
   i2cs_pkg::phase_type phase_in;
   logic                busy_ff;
   logic                busy_in;
   logic [PW-1:0]       tx_pos_ff;
   logic [PW-1:0]       tx_pos_in;
   logic [RW-1:0]       rx_pos_ff;
   logic [RW-1:0]       rx_pos_in;
   logic [6:0]          own_addr_ff;

   // step outputs
   i2cs_pkg::phase_type step_phase;
   logic                step_busy;
   logic [PW-1:0]       step_tx_pos;
   logic [RW-1:0]       step_rx_pos;
   i2cs_pkg::rsp_type   step_rsp;

   logic       fire;
   logic       req_take;
   logic [7:0] head;

   // advance the held event whenever the response register is free or draining
   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   // hold state unless an event is processed
   assign phase_in  = fire ? step_phase  : phase_ff;
   assign busy_in   = fire ? step_busy   : busy_ff;
   assign tx_pos_in = fire ? step_tx_pos : tx_pos_ff;
   assign rx_pos_in = fire ? step_rx_pos : rx_pos_ff;

   i2cs_step #(
      .TX_DEPTH (TX_DEPTH),
      .RX_COUNT (RX_COUNT)
   ) u_step (
      .req         (in_data_ff),
      .phase       (phase_ff),
      .busy        (busy_ff),
      .tx_pos      (tx_pos_ff),
      .rx_pos      (rx_pos_ff),
      .head        (head),
      .own_address (own_addr_ff),
      .phase_in    (step_phase),
      .busy_in     (step_busy),
      .tx_pos_in   (step_tx_pos),
      .rx_pos_in   (step_rx_pos),
      .rsp         (step_rsp)
   );

   // prefetch the byte at the next transmit position
   i2cs_txbuf #(
      .TX_DEPTH (TX_DEPTH)
   ) u_txbuf (
      .clock    (clock),
      .reset    (reset),
      .wr_req   (fire && (in_data_ff.operation == i2cs_pkg::OP_LOAD)),
      .wr_index (in_data_ff.tx_index),
      .wr_byte  (in_data_ff.tx_byte),
      .rd_pos   (tx_pos_in),
      .head     (head)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= i2cs_pkg::PH_IDLE;
         busy_ff      <= 1'b0;
         tx_pos_ff    <= '0;
         rx_pos_ff    <= '0;
         own_addr_ff  <= 7'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         busy_ff      <= busy_in;
         tx_pos_ff    <= tx_pos_in;
         rx_pos_ff    <= rx_pos_in;
         if (csr_valid && csr_ready) begin
            own_addr_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
